FILE: hw/rtl/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types and constants of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int CNT_W      = $clog2(CELLS + 1);

    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int OFS_W      = 11;
    localparam int LINES_W    = 5;
    localparam int BYTE_W     = 8;
    localparam int TAB_W      = 7;
    localparam int MODE_W     = 3;

    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 40;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h07;
    localparam logic [TAB_W-1:0]  TAB_RESET  = 7'd20;

    localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;

    // register index, taken from paddr[2]
    localparam logic REG_ATTR = 1'b0;
    localparam logic REG_TAB  = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_PRINT  = 3'd0,
        MODE_READ   = 3'd1,
        MODE_SET    = 3'd2,
        MODE_CLEAR  = 3'd3,
        MODE_SCROLL = 3'd4
    } mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] attribute;
        logic [TAB_W-1:0]  tab_width;
    } cfg_t;

endpackage
`default_nettype wire

FILE: hw/rtl/text_console_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer
// teletype engine over an 80 x 25 character and attribute cell store
// ----------------------------------------------------------------------------
// one command word in on s_ (mode in s_tuser), one result word out on m_ for
// every command: cursor column, row, linear offset and, for a cell read, the
// cell's character and attribute. attribute and tab width sit on the apb port.
// path of each command from acceptance to the result being offered:
//   printable byte, backspace, cr, lf, set cursor, scroll by zero: result registered at acceptance
//   read cell: the registered ram read, then ST_READ loads the result
//   tab: waits for the 7-step column remainder divider
//   clear screen, scroll, print that runs off the last row: a sweep of the store,
//   one cell per cycle through the write ports of both rams on one shared address
// after reset the store is swept to character 0, attribute 7: s_tready
// stays low until the sweep is done; apb writes are taken throughout.
// a held result does not block the next command from being accepted; that
// command completes internally and waits for the result register to drain.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // s_tdata: ch[7:0], col[14:8], row[19:15], lines[24:20], zero fill
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: mode[2:0]
    input  wire logic [MODE_W-1:0]     s_tuser,
    // m_tdata: cursor_col[6:0], cursor_row[11:7], cursor_offset[22:12],
    // cell_char[30:23], cell_attr[38:31], zero fill
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_COPY,
        ST_BLANK,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             clr;
    } pos_t;

    function automatic pos_t wrap_pos(input logic [COL_W:0]   c,
                                      input logic [ROW_W-1:0] r,
                                      input logic             inc);
        logic [ROW_W:0] ln;
        pos_t           p;
        ln    = {1'b0, r} + (ROW_W + 1)'(inc);
        p.col = c[COL_W-1:0];
        if (c >= (COL_W + 1)'(COLUMNS)) begin
            p.col = '0;
            ln    = ln + 1'b1;
        end
        p.clr = (ln >= (ROW_W + 1)'(ROWS));
        p.row = ln[ROW_W-1:0];
        if (p.clr) begin
            p.col = '0;
            p.row = '0;
        end
        return p;
    endfunction

    function automatic logic [OFS_W-1:0] cell_ofs(input logic [COL_W-1:0] c,
                                                  input logic [ROW_W-1:0] r);
        return OFS_W'(r) * OFS_W'(COLUMNS) + OFS_W'(c);
    endfunction

    cfg_t cfg;

    state_t            state_reg;
    logic [COL_W-1:0]  cur_col_reg;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [BYTE_W-1:0] res_char_reg;
    logic [BYTE_W-1:0] res_attr_reg;
    logic [CNT_W-1:0]  rd_idx_reg;
    logic [CNT_W-1:0]  wr_idx_reg;
    logic              cp_pend_reg;
    logic [BYTE_W-1:0] fill_attr_reg;
    logic              m_valid_reg;
    logic [COL_W-1:0]  m_col_reg;
    logic [ROW_W-1:0]  m_row_reg;
    logic [OFS_W-1:0]  m_ofs_reg;
    logic [BYTE_W-1:0] m_char_reg;
    logic [BYTE_W-1:0] m_attr_reg;

    logic [BYTE_W-1:0]  in_ch;
    logic [COL_W-1:0]   in_col;
    logic [ROW_W-1:0]   in_row;
    logic [LINES_W-1:0] in_lines;
    mode_t              in_mode;
    logic               acc;
    logic               out_free;

    logic [COL_W-1:0]   sat_col;
    logic [ROW_W-1:0]   sat_row;
    logic [LINES_W-1:0] n_lines;
    logic [CNT_W-1:0]   shift_cnt;
    logic [TAB_W-1:0]   tw_eff;
    logic [ADDR_W-1:0]  cur_idx;
    logic [ADDR_W-1:0]  rd_cell_idx;

    logic [COL_W:0]     pr_col;
    logic               pr_inc;
    logic               pr_wr;
    logic               bs_wr;
    pos_t               pw;
    logic [COL_W:0]     tab_col;
    pos_t               tw;

    logic [COL_W-1:0]   act_col;
    logic [ROW_W-1:0]   act_row;
    logic               act_fin;
    state_t             act_state;

    logic               div_start;
    logic               div_done;
    logic [COL_W-1:0]   div_rem;

    logic               rd_go;

    logic               we_char;
    logic               we_attr;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [BYTE_W-1:0]  ram_wchar;
    logic [BYTE_W-1:0]  ram_wattr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [BYTE_W-1:0]  ram_rchar;
    logic [BYTE_W-1:0]  ram_rattr;

    tcw_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcw_tab_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (cur_col_reg),
        .divisor  (tw_eff),
        .done     (div_done),
        .rem      (div_rem)
    );

    tcw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CELLS)
    ) u_char_ram (
        .aclk  (aclk),
        .we    (we_char),
        .waddr (ram_waddr),
        .wdata (ram_wchar),
        .raddr (ram_raddr),
        .rdata (ram_rchar)
    );

    tcw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CELLS)
    ) u_attr_ram (
        .aclk  (aclk),
        .we    (we_attr),
        .waddr (ram_waddr),
        .wdata (ram_wattr),
        .raddr (ram_raddr),
        .rdata (ram_rattr)
    );

    assign in_ch    = s_tdata[7:0];
    assign in_col   = s_tdata[14:8];
    assign in_row   = s_tdata[19:15];
    assign in_lines = s_tdata[24:20];
    assign in_mode  = mode_t'(s_tuser);

    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign sat_col   = (in_col > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : in_col;
    assign sat_row   = (in_row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : in_row;
    assign n_lines   = (in_lines > LINES_W'(ROWS)) ? LINES_W'(ROWS) : in_lines;
    assign shift_cnt = CNT_W'(n_lines) * CNT_W'(COLUMNS);
    assign tw_eff    = (cfg.tab_width == '0) ? TAB_W'(1) : cfg.tab_width;

    assign cur_idx     = ADDR_W'(cur_row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_reg);
    assign rd_cell_idx = ADDR_W'(sat_row) * ADDR_W'(COLUMNS) + ADDR_W'(sat_col);

    assign div_start = acc && (in_mode == MODE_PRINT) && (in_ch == CH_TAB);
    assign rd_go     = (rd_idx_reg < CNT_W'(CELLS));

    // immediate print: backspace, line break, printable byte
    always_comb begin
        pr_col = {1'b0, cur_col_reg};
        pr_inc = 1'b0;
        pr_wr  = 1'b0;
        bs_wr  = 1'b0;
        unique case (in_ch)
            CH_BS: begin
                if (cur_col_reg != '0) begin
                    pr_col = pr_col - 1'b1;
                    bs_wr  = 1'b1;
                end
            end
            CH_TAB: begin
                pr_col = {1'b0, cur_col_reg};
            end
            CH_CR, CH_LF: begin
                pr_col = '0;
                pr_inc = 1'b1;
            end
            default: begin
                pr_col = pr_col + 1'b1;
                pr_wr  = 1'b1;
            end
        endcase
    end

    assign pw      = wrap_pos(pr_col, cur_row_reg, pr_inc);
    assign tab_col = {1'b0, cur_col_reg} + {1'b0, tw_eff} - {1'b0, div_rem};
    assign tw      = wrap_pos(tab_col, cur_row_reg, 1'b0);

    // command decode in idle
    always_comb begin
        act_col   = cur_col_reg;
        act_row   = cur_row_reg;
        act_fin   = 1'b1;
        act_state = ST_IDLE;
        unique case (in_mode)
            MODE_PRINT: begin
                if (in_ch == CH_TAB) begin
                    act_fin   = 1'b0;
                    act_state = ST_DIV;
                end else begin
                    act_col = pw.col;
                    act_row = pw.row;
                    if (pw.clr) begin
                        act_fin   = 1'b0;
                        act_state = ST_BLANK;
                    end
                end
            end
            MODE_READ: begin
                act_fin   = 1'b0;
                act_state = ST_READ;
            end
            MODE_SET: begin
                act_col = sat_col;
                act_row = sat_row;
            end
            MODE_CLEAR: begin
                act_col   = '0;
                act_row   = '0;
                act_fin   = 1'b0;
                act_state = ST_BLANK;
            end
            MODE_SCROLL: begin
                if (n_lines != '0) begin
                    act_fin   = 1'b0;
                    act_state = ST_COPY;
                    if (LINES_W'(cur_row_reg) < n_lines) begin
                        act_col = '0;
                        act_row = '0;
                    end else begin
                        act_row = cur_row_reg - ROW_W'(n_lines);
                    end
                end
            end
            default: begin
                act_fin = 1'b1;
            end
        endcase
    end

    // cell store port control
    always_comb begin
        we_char   = 1'b0;
        we_attr   = 1'b0;
        ram_waddr = wr_idx_reg[ADDR_W-1:0];
        ram_wchar = '0;
        ram_wattr = fill_attr_reg;
        ram_raddr = rd_cell_idx;
        unique case (state_reg)
            ST_INIT: begin
                we_char   = 1'b1;
                we_attr   = 1'b1;
                ram_wattr = ATTR_RESET;
            end
            ST_BLANK: begin
                we_char = 1'b1;
                we_attr = 1'b1;
            end
            ST_COPY: begin
                we_char   = cp_pend_reg;
                we_attr   = cp_pend_reg;
                ram_wchar = ram_rchar;
                ram_wattr = ram_rattr;
                ram_raddr = rd_idx_reg[ADDR_W-1:0];
            end
            ST_IDLE: begin
                if (acc && (in_mode == MODE_PRINT)) begin
                    if (pr_wr) begin
                        we_char   = 1'b1;
                        we_attr   = 1'b1;
                        ram_waddr = cur_idx;
                        ram_wchar = in_ch;
                        ram_wattr = cfg.attribute;
                    end else if (bs_wr) begin
                        we_char   = 1'b1;
                        ram_waddr = cur_idx - 1'b1;
                    end
                end
            end
            default: begin
                we_char = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            cp_pend_reg <= 1'b0;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_INIT: begin
                    wr_idx_reg <= wr_idx_reg + 1'b1;
                    if (wr_idx_reg == CNT_W'(CELLS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (acc) begin
                        cur_col_reg   <= act_col;
                        cur_row_reg   <= act_row;
                        res_char_reg  <= '0;
                        res_attr_reg  <= '0;
                        wr_idx_reg    <= '0;
                        rd_idx_reg    <= shift_cnt;
                        cp_pend_reg   <= 1'b0;
                        fill_attr_reg <= cfg.attribute;
                        if (act_fin) begin
                            if (out_free) begin
                                m_valid_reg <= 1'b1;
                                m_col_reg   <= act_col;
                                m_row_reg   <= act_row;
                                m_ofs_reg   <= cell_ofs(act_col, act_row);
                                m_char_reg  <= '0;
                                m_attr_reg  <= '0;
                            end else begin
                                state_reg <= ST_FIN;
                            end
                        end else begin
                            state_reg <= act_state;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        cur_col_reg <= tw.col;
                        cur_row_reg <= tw.row;
                        state_reg   <= tw.clr ? ST_BLANK : ST_FIN;
                    end
                end
                ST_READ: begin
                    res_char_reg <= ram_rchar;
                    res_attr_reg <= ram_rattr;
                    state_reg    <= ST_FIN;
                end
                ST_COPY: begin
                    if (rd_go) begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                    cp_pend_reg <= rd_go;
                    if (cp_pend_reg) begin
                        wr_idx_reg <= wr_idx_reg + 1'b1;
                    end
                    if (!rd_go && !cp_pend_reg) begin
                        state_reg <= ST_BLANK;
                    end
                end
                ST_BLANK: begin
                    wr_idx_reg <= wr_idx_reg + 1'b1;
                    if (wr_idx_reg >= CNT_W'(CELLS - 1)) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_col_reg   <= cur_col_reg;
                        m_row_reg   <= cur_row_reg;
                        m_ofs_reg   <= cell_ofs(cur_col_reg, cur_row_reg);
                        m_char_reg  <= res_char_reg;
                        m_attr_reg  <= res_attr_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_INIT;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_attr_reg, m_char_reg, m_ofs_reg, m_row_reg, m_col_reg};

endmodule
`default_nettype wire

FILE: hw/rtl/tcw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: hw/rtl/tcw_tab_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_tab_div
// restoring divider, one quotient bit per cycle, gives the remainder of
// the cursor column by the tab width
// ----------------------------------------------------------------------------
module tcw_tab_div
    import tcw_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [COL_W-1:0] dividend,
    input  wire logic [COL_W-1:0] divisor,
    output logic                  done,
    output logic      [COL_W-1:0] rem
);

    localparam int STEP_W = $clog2(COL_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [COL_W-1:0]  quo_reg;
    logic [COL_W-1:0]  div_reg;
    logic [COL_W:0]    rem_reg;
    logic [COL_W:0]    trial;
    logic [COL_W:0]    rem_next;

    always_comb begin
        trial = {rem_reg[COL_W-1:0], quo_reg[COL_W-1]};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = trial - {1'b0, div_reg};
        end else begin
            rem_next = trial;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                quo_reg  <= dividend;
                div_reg  <= divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg  <= rem_next;
                quo_reg  <= {quo_reg[COL_W-2:0], 1'b0};
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(COL_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg[COL_W-1:0];

endmodule
`default_nettype wire

FILE: hw/rtl/tcw_apb_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_apb_regs
// apb register file: attribute byte and tab stop spacing
// ----------------------------------------------------------------------------
module tcw_apb_regs
    import tcw_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    logic wr_en;
    logic reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attribute <= ATTR_RESET;
            cfg_reg.tab_width <= TAB_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_ATTR: cfg_reg.attribute <= pwdata[BYTE_W-1:0];
                REG_TAB:  cfg_reg.tab_width <= pwdata[TAB_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_ATTR: prdata = APB_DATA_W'(cfg_reg.attribute);
            REG_TAB:  prdata = APB_DATA_W'(cfg_reg.tab_width);
        endcase
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/tcw_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_checker
// port-level checks of the text console writer, bound to the top level
// ----------------------------------------------------------------------------
module tcw_checker
    import tcw_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // result word held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // store sweep after reset blocks commands
    a_init_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("command accepted during reset sweep");

    // cursor inside the screen
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] < 7'(COLUMNS)) && (m_tdata[11:7] < 5'(ROWS)))
        else $error("cursor outside screen");

    // offset matches row and column
    a_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[22:12] ==
            11'(m_tdata[11:7]) * 11'(COLUMNS) + 11'(m_tdata[6:0]))
        else $error("cursor offset mismatch");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
`default_nettype wire
